// ----- rtl/tsmv_pkg.sv -----
// Shared types and constants for the triple sample margin voter.
// No dependencies; imported by the lane, merge, top level and checker.
`default_nettype none

package tsmv_pkg;

   // Reading and margin width in bits
   localparam int SAMPLE_W = 14;
   // Sum of three readings
   localparam int SUM_W    = SAMPLE_W + 2;
   // Number of redundant readings
   localparam int NUM_LANES = 3;

   // Divide by three: floor(x * 43691 / 2^17) is exact for x below 2^17
   localparam logic [15:0] RECIP3       = 16'd43691;
   localparam int          RECIP3_SHIFT = 17;
   localparam int          PROD_W       = SUM_W + 16;

   // Margin reset values
   localparam logic [SAMPLE_W-1:0] PRECISE_LIMIT_RST = 14'd400;
   localparam logic [SAMPLE_W-1:0] ACCEPT_LIMIT_RST  = 14'd800;

   // Register indexes (address bit 2)
   localparam logic REG_PRECISE_LIMIT = 1'b0;
   localparam logic REG_ACCEPT_LIMIT  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_PRECISION  = 2'd1,
      ST_ACCEPTABLE = 2'd2,
      ST_ERROR      = 2'd3
   } vote_status_type;

   // What one lane found about its reading
   typedef struct packed {
      logic precise;     // deviation below low margin
      logic acceptable;  // deviation below high margin
   } lane_flags_type;

endpackage : tsmv_pkg

`default_nettype wire

// ----- rtl/tsmv_lane.sv -----
// One voting lane: absolute deviation of a reading from the mean and its
// compare against both margins. Depends on tsmv_pkg.
`default_nettype none

module tsmv_lane
   import tsmv_pkg::*;
(
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [SAMPLE_W-1:0] mean,
   input  wire logic [SAMPLE_W-1:0] precise_limit,
   input  wire logic [SAMPLE_W-1:0] accept_limit,
   output lane_flags_type           flags
);

   logic [SAMPLE_W-1:0] deviation;

   // |sample - mean|
   always_comb begin
      if (sample >= mean) begin
         deviation = sample - mean;
      end else begin
         deviation = mean - sample;
      end
   end

   // strict compares; a zero margin passes nothing
   assign flags.precise    = (deviation < precise_limit);
   assign flags.acceptable = (deviation < accept_limit);

endmodule : tsmv_lane

`default_nettype wire

// ----- rtl/tsmv_merge.sv -----
// Merging stage: combines the three lanes' flags into the voted value and
// status: the mean, a pair average, one reading or zero. Depends on tsmv_pkg.
`default_nettype none

module tsmv_merge
   import tsmv_pkg::*;
(
   input  wire logic [SAMPLE_W-1:0] sample [NUM_LANES],
   input  wire logic [SAMPLE_W-1:0] mean,
   input  wire lane_flags_type      flags  [NUM_LANES],
   output logic [SAMPLE_W-1:0]      voted_value,
   output vote_status_type          vote_status
);

   logic [SAMPLE_W:0]   sum_bc, sum_ac, sum_ab;
   logic [SAMPLE_W-1:0] avg_bc, avg_ac, avg_ab;
   logic lo0, lo1, lo2, hi0, hi1, hi2;

   // pair averages, truncated
   assign sum_bc = {1'b0, sample[1]} + {1'b0, sample[2]};
   assign sum_ac = {1'b0, sample[0]} + {1'b0, sample[2]};
   assign sum_ab = {1'b0, sample[0]} + {1'b0, sample[1]};
   assign avg_bc = sum_bc[SAMPLE_W:1];
   assign avg_ac = sum_ac[SAMPLE_W:1];
   assign avg_ab = sum_ab[SAMPLE_W:1];

   assign lo0 = flags[0].precise;
   assign lo1 = flags[1].precise;
   assign lo2 = flags[2].precise;
   assign hi0 = flags[0].acceptable;
   assign hi1 = flags[1].acceptable;
   assign hi2 = flags[2].acceptable;

   // priority vote: first matching test wins
   always_comb begin
      if ((mean == '0) || (lo0 && lo1 && lo2)) begin
         voted_value = mean;
         vote_status = ST_OK;
      end else if (hi0 && lo1 && lo2) begin
         voted_value = avg_bc;
         vote_status = ST_PRECISION;
      end else if (lo0 && hi1 && lo2) begin
         voted_value = avg_ac;
         vote_status = ST_PRECISION;
      end else if (lo0 && lo1 && hi2) begin
         voted_value = avg_ab;
         vote_status = ST_PRECISION;
      end else if (hi0 && hi1 && lo2) begin
         voted_value = sample[2];
         vote_status = ST_ACCEPTABLE;
      end else if (hi0 && lo1 && hi2) begin
         voted_value = sample[1];
         vote_status = ST_ACCEPTABLE;
      end else if (lo0 && hi1 && hi2) begin
         voted_value = sample[0];
         vote_status = ST_ACCEPTABLE;
      end else begin
         voted_value = '0;
         vote_status = ST_ERROR;
      end
   end

endmodule : tsmv_merge

`default_nettype wire

// ----- rtl/triple_sample_margin_voter.sv -----
// Triple sample margin voter, top level: margin registers, four-stage pipeline.
// Items pass through the registered stages in order: sum, divide-by-3 multiply,
// three parallel deviation lanes, merge into the output register; rsp_valid
// rises when an item reaches the output register. Throughput: one item per
// cycle while rsp_stall does not hold the full pipeline (then req_stall rises).
// Reset (synchronous): pipeline emptied, margins back to 400 and 800.
`default_nettype none

module triple_sample_margin_voter
   import tsmv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample_a,
   input  wire logic [SAMPLE_W-1:0] req_sample_b,
   input  wire logic [SAMPLE_W-1:0] req_sample_c,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_voted_value,
   output logic [1:0]               rsp_vote_status,
   // configuration port
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   // ---------------- configuration registers ----------------
   logic [SAMPLE_W-1:0] precise_limit_ff, accept_limit_ff;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         precise_limit_ff <= PRECISE_LIMIT_RST;
         accept_limit_ff  <= ACCEPT_LIMIT_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_PRECISE_LIMIT) begin
            precise_limit_ff <= csr_pwdata[SAMPLE_W-1:0];
         end else begin
            accept_limit_ff <= csr_pwdata[SAMPLE_W-1:0];
         end
      end
   end

   // readback
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PRECISE_LIMIT) begin
         csr_prdata[SAMPLE_W-1:0] = precise_limit_ff;
      end else begin
         csr_prdata[SAMPLE_W-1:0] = accept_limit_ff;
      end
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv;   // stage takes a new item
   logic s4_rdy, s3_rdy, s2_rdy, s1_rdy;

   assign s4_rdy = !s4_valid_ff || !rsp_stall;
   assign s3_rdy = !s3_valid_ff || s4_rdy;
   assign s2_rdy = !s2_valid_ff || s3_rdy;
   assign s1_rdy = !s1_valid_ff || s2_rdy;

   assign req_stall = !s1_rdy;
   assign s1_adv    = s1_rdy;
   assign s2_adv    = s2_rdy;
   assign s3_adv    = s3_rdy;
   assign s4_adv    = s4_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
         if (s4_adv) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: sum ----------------
   logic [SAMPLE_W-1:0] s1_sample_ff [NUM_LANES];
   logic [SUM_W-1:0]    s1_sum_ff, s1_sum_in;

   assign s1_sum_in = SUM_W'(req_sample_a) + SUM_W'(req_sample_b) + SUM_W'(req_sample_c);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_sample_ff[0] <= req_sample_a;
         s1_sample_ff[1] <= req_sample_b;
         s1_sample_ff[2] <= req_sample_c;
         s1_sum_ff       <= s1_sum_in;
      end
   end

   // ---------------- stage 2: mean = sum / 3 ----------------
   logic [SAMPLE_W-1:0] s2_sample_ff [NUM_LANES];
   logic [SAMPLE_W-1:0] s2_mean_ff, s2_mean_in;
   logic [PROD_W-1:0]   s2_prod;

   assign s2_prod    = PROD_W'(s1_sum_ff) * PROD_W'(RECIP3);
   assign s2_mean_in = s2_prod[RECIP3_SHIFT +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_sample_ff <= s1_sample_ff;
         s2_mean_ff   <= s2_mean_in;
      end
   end

   // ---------------- stage 3: deviation lanes ----------------
   logic [SAMPLE_W-1:0] s3_sample_ff [NUM_LANES];
   logic [SAMPLE_W-1:0] s3_mean_ff;
   lane_flags_type      s3_flags_ff [NUM_LANES];
   lane_flags_type      s3_flags_in [NUM_LANES];

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      tsmv_lane u_lane (
         .sample        (s2_sample_ff[g]),
         .mean          (s2_mean_ff),
         .precise_limit (precise_limit_ff),
         .accept_limit  (accept_limit_ff),
         .flags         (s3_flags_in[g])
      );
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_sample_ff <= s2_sample_ff;
         s3_mean_ff   <= s2_mean_ff;
         s3_flags_ff  <= s3_flags_in;
      end
   end

   // ---------------- stage 4: merge into output register ----------------
   logic [SAMPLE_W-1:0] s4_value_ff, s4_value_in;
   vote_status_type     s4_status_ff, s4_status_in;

   tsmv_merge u_merge (
      .sample      (s3_sample_ff),
      .mean        (s3_mean_ff),
      .flags       (s3_flags_ff),
      .voted_value (s4_value_in),
      .vote_status (s4_status_in)
   );

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_value_ff  <= s4_value_in;
         s4_status_ff <= s4_status_in;
      end
   end

   assign rsp_valid       = s4_valid_ff;
   assign rsp_voted_value = s4_value_ff;
   assign rsp_vote_status = s4_status_ff;

endmodule : triple_sample_margin_voter

`default_nettype wire

// ----- rtl/tsmv_checker.sv -----
// Port-level checker for the triple sample margin voter, bound to the top
// level. Depends on tsmv_pkg and triple_sample_margin_voter.
`default_nettype none

module tsmv_checker
   import tsmv_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [SAMPLE_W-1:0] rsp_voted_value,
   input wire logic [1:0]          rsp_vote_status,
   input wire logic                csr_pready
);

   // a comparison error always reports a zero value
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_vote_status == ST_ERROR)) |-> (rsp_voted_value == '0))
      else $error("comparison error with nonzero value");

   // empty output means the whole pipeline can take an item
   a_no_idle_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

   // nothing comes out right after a reset cycle
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_voted_value) && $stable(rsp_vote_status)))
      else $error("stalled result changed");

   // configuration port never waits
   a_pready : assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule : tsmv_checker

bind triple_sample_margin_voter tsmv_checker u_tsmv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_voted_value (rsp_voted_value),
   .rsp_vote_status (rsp_vote_status),
   .csr_pready      (csr_pready)
);

`default_nettype wire

// ----- dv/tb_triple_sample_margin_voter.sv -----
// Self-checking testbench for triple_sample_margin_voter: random and directed
// sample triples over several margin settings, with stalls on both channels.
// Depends on rtl/tsmv_pkg.sv and rtl/triple_sample_margin_voter.sv.
`timescale 1ns / 100ps

module tb_triple_sample_margin_voter;
   import tsmv_pkg::*;

   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam int NUM_PHASES = 9;
   localparam int PHASE_ITEMS = 152;
   localparam int HOLD_CYCLES = 80;

   // One predicted result
   typedef struct {
      logic [SAMPLE_W-1:0] value;
      vote_status_type     status;
   } vote_expect_type;

   // Margin copy, vote prediction and in-order store of expected votes
   class vote_ledger;
      logic [SAMPLE_W-1:0] precise_limit = PRECISE_LIMIT_RST;
      logic [SAMPLE_W-1:0] accept_limit  = ACCEPT_LIMIT_RST;
      vote_expect_type     pending_votes[$];
      int                  failures = 0;

      function void set_margin(logic reg_index, logic [SAMPLE_W-1:0] value);
         if (reg_index == REG_PRECISE_LIMIT) precise_limit = value;
         else accept_limit = value;
      endfunction

      function int count();
         return pending_votes.size();
      endfunction

      function vote_expect_type compute_vote(logic [SAMPLE_W-1:0] a, b, c);
         int              s[3];
         int              mean;
         int              dev;
         bit              lo[3];
         bit              hi[3];
         int              val;
         vote_expect_type r;
         s[0] = a;
         s[1] = b;
         s[2] = c;
         mean = (s[0] + s[1] + s[2]) / 3;
         for (int i = 0; i < 3; i++) begin
            dev   = (s[i] >= mean) ? s[i] - mean : mean - s[i];
            lo[i] = dev < int'(precise_limit);
            hi[i] = dev < int'(accept_limit);
         end
         // first matching rule wins
         if (mean == 0 || (lo[0] && lo[1] && lo[2])) begin
            val = mean;
            r.status = ST_OK;
         end else if (hi[0] && lo[1] && lo[2]) begin
            val = (s[1] + s[2]) / 2;
            r.status = ST_PRECISION;
         end else if (lo[0] && hi[1] && lo[2]) begin
            val = (s[0] + s[2]) / 2;
            r.status = ST_PRECISION;
         end else if (lo[0] && lo[1] && hi[2]) begin
            val = (s[0] + s[1]) / 2;
            r.status = ST_PRECISION;
         end else if (hi[0] && hi[1] && lo[2]) begin
            val = s[2];
            r.status = ST_ACCEPTABLE;
         end else if (hi[0] && lo[1] && hi[2]) begin
            val = s[1];
            r.status = ST_ACCEPTABLE;
         end else if (lo[0] && hi[1] && hi[2]) begin
            val = s[0];
            r.status = ST_ACCEPTABLE;
         end else begin
            val = 0;
            r.status = ST_ERROR;
         end
         r.value = val[SAMPLE_W-1:0];
         return r;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] a, b, c);
         pending_votes.push_back(compute_vote(a, b, c));
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] value, logic [1:0] status);
         vote_expect_type exp_vote;
         if (pending_votes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result with none expected: value %0d status %0d",
                        $time, value, status);
            return;
         end
         exp_vote = pending_votes.pop_front();
         if (value !== exp_vote.value || status !== exp_vote.status) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch: expected value %0d status %s, got value %0d status %0d",
                        $time, exp_vote.value, exp_vote.status.name(), value, status);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_a = '0;
   logic [SAMPLE_W-1:0] req_sample_b = '0;
   logic [SAMPLE_W-1:0] req_sample_c = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_voted_value;
   logic [1:0]          rsp_vote_status;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   vote_ledger votes = new();

   // receiver control
   bit rsp_idle_on = 1'b0;
   int hold_requests = 0;

   triple_sample_margin_voter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_a    (req_sample_a),
      .req_sample_b    (req_sample_b),
      .req_sample_c    (req_sample_c),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_voted_value (rsp_voted_value),
      .rsp_vote_status (rsp_vote_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Idle length: mostly short, a few long
   function automatic int pick_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
   endfunction

   // Triple: random, at the ends, or near a base with margin-scaled offsets
   function automatic logic [3*SAMPLE_W-1:0] random_triple(int lo, int hi);
      int s[3];
      int base;
      int span;
      int off;
      case ($urandom_range(0, 9))
         0: for (int i = 0; i < 3; i++) s[i] = $urandom_range(0, SAMPLE_MAX);
         1: for (int i = 0; i < 3; i++)
               s[i] = $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 3)
                                           : $urandom_range(0, 3);
         default: begin
            base = $urandom_range(0, SAMPLE_MAX);
            for (int i = 0; i < 3; i++) begin
               span = ($urandom_range(0, 4) < 3) ? lo / 3 : (3 * hi) / 2 + 8;
               off  = $urandom_range(0, span);
               s[i] = $urandom_range(0, 1) ? base + off : base - off;
               if (s[i] < 0) s[i] = 0;
               if (s[i] > SAMPLE_MAX) s[i] = SAMPLE_MAX;
            end
         end
      endcase
      return {s[0][SAMPLE_W-1:0], s[1][SAMPLE_W-1:0], s[2][SAMPLE_W-1:0]};
   endfunction

   // Offer one item and hold it until accepted
   task automatic send_triple(input logic [SAMPLE_W-1:0] a, b, c);
      req_valid    <= 1'b1;
      req_sample_a <= a;
      req_sample_b <= b;
      req_sample_c <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      votes.note_sample(a, b, c);
   endtask

   task automatic sender_gap(input bit idle_on);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender is idle: wait for every expected vote, then for the pipeline
   task automatic drain_votes();
      while (votes.count() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Setup and access cycle; upper data bits sometimes junk
   task automatic write_margin(input logic reg_index, input logic [SAMPLE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= {($urandom_range(0, 1) ? 18'($urandom) : 18'd0), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      votes.set_margin(reg_index, value);
      @(posedge clock);
   endtask

   // Result side: check accepted items, then choose the next stall
   initial begin
      int stall_left;
      int hold_left;
      int holds_served;
      stall_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            votes.check_result(rsp_voted_value, rsp_vote_status);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus
   initial begin
      logic [3*SAMPLE_W-1:0] directed_list[] = '{
         {14'd0, 14'd0, 14'd0},
         {14'd16383, 14'd16383, 14'd16383},
         {14'd0, 14'd0, 14'd16383},
         {14'd16383, 14'd0, 14'd0},
         {14'd0, 14'd0, 14'd2},           // mean truncates to zero
         {14'd1, 14'd1, 14'd1},
         {14'd12288, 14'd12288, 14'd12288},
         {14'd12289, 14'd12290, 14'd12291}, // above nominal range
         {14'd10922, 14'd5461, 14'd16383},
         {14'd5461, 14'd10922, 14'd0},
         {14'd1000, 14'd1010, 14'd990},   // all precise
         {14'd1600, 14'd1000, 14'd1000},  // one acceptable: a, b, c
         {14'd1000, 14'd1600, 14'd1000},
         {14'd1000, 14'd1000, 14'd1600},
         {14'd1600, 14'd400, 14'd1000},   // two acceptable: precise c, b, a
         {14'd1600, 14'd1000, 14'd400},
         {14'd1000, 14'd1600, 14'd400},
         {14'd0, 14'd5000, 14'd10000},    // comparison error
         {14'd1400, 14'd1000, 14'd1000},
         {14'd1000, 14'd1000, 14'd1801}
      };
      int phase_lo[NUM_PHASES] = '{400, 0, 16383, 800, 1, 12288, -1, 0, 30};
      int phase_hi[NUM_PHASES] = '{800, 0, 16383, 400, 2, 12288, -1, 16383, 90};
      logic [3*SAMPLE_W-1:0] trip;
      int  lo_val;
      int  hi_val;
      bit  send_idle;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at reset margins, no idling
      foreach (directed_list[i]) begin
         trip = directed_list[i];
         send_triple(trip[3*SAMPLE_W-1:2*SAMPLE_W], trip[2*SAMPLE_W-1:SAMPLE_W],
                     trip[SAMPLE_W-1:0]);
      end
      req_valid <= 1'b0;

      // Random phases, one margin setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_votes();
         lo_val = (phase_lo[p] < 0) ? $urandom_range(0, SAMPLE_MAX) : phase_lo[p];
         hi_val = (phase_hi[p] < 0) ? $urandom_range(0, SAMPLE_MAX) : phase_hi[p];
         write_margin(REG_PRECISE_LIMIT, lo_val[SAMPLE_W-1:0]);
         write_margin(REG_ACCEPT_LIMIT, hi_val[SAMPLE_W-1:0]);
         send_idle   = (p % 3 != 0) && (p != 2);
         rsp_idle_on = (p % 3 != 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold while items keep coming
            if (p == 2 && n == 10) hold_requests++;
            trip = random_triple(lo_val, hi_val);
            send_triple(trip[3*SAMPLE_W-1:2*SAMPLE_W], trip[2*SAMPLE_W-1:SAMPLE_W],
                        trip[SAMPLE_W-1:0]);
            if (p == 4 && n == 60) begin
               req_valid <= 1'b0;
               while (votes.count() != 0) @(posedge clock);
            end else begin
               sender_gap(send_idle);
            end
         end
         req_valid <= 1'b0;
      end

      // Wait for the tail, then report
      while (votes.count() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (votes.failures == 0 && votes.count() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- triple_sample_margin_voter.f -----
rtl/tsmv_pkg.sv
rtl/tsmv_lane.sv
rtl/tsmv_merge.sv
rtl/triple_sample_margin_voter.sv
rtl/tsmv_checker.sv
dv/tb_triple_sample_margin_voter.sv
